// ===== hw/rtl/clbs_pkg.sv =====
package clbs_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  // request codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_INIT  = 1'b1;

  // strobe phases of one bus word, also the hold time in ms
  localparam logic [1:0] PH_PLACE  = 2'd0;
  localparam logic [1:0] PH_EN_HI  = 2'd1;
  localparam logic [1:0] PH_EN_LO  = 2'd2;

  // init word indexes
  localparam logic [2:0] IDX_PREFIX  = 3'd0;
  localparam logic [2:0] IDX_FUNC    = 3'd1;
  localparam logic [2:0] IDX_DISPLAY = 3'd2;
  localparam logic [2:0] IDX_CLEAR   = 3'd3;
  localparam logic [2:0] IDX_ENTRY   = 3'd4;

  localparam logic [7:0] INIT_PREFIX    = 8'h20;
  localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       use_rom;
    logic [2:0] rom_idx;
    logic       nib_lo;
    logic [1:0] phase;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_init;
    logic wide_bus;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic eight);
    logic [7:0] b;
    case (idx)
      IDX_PREFIX:  b = INIT_PREFIX;
      IDX_FUNC:    b = eight ? CMD_FUNC_8BIT : CMD_FUNC_4BIT;
      IDX_DISPLAY: b = CMD_DISPLAY_ON;
      IDX_CLEAR:   b = CMD_CLEAR;
      IDX_ENTRY:   b = CMD_ENTRY_MODE;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/clbs_req_if.sv =====
interface clbs_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       reg_select;
  logic [7:0] byte_value;

  modport source (output valid, cmd, reg_select, byte_value, input ready);
  modport sink (input valid, cmd, reg_select, byte_value, output ready);
endinterface

// ===== hw/rtl/clbs_upd_if.sv =====
interface clbs_upd_if;
  logic       valid;
  logic       ready;
  logic       rs_pin;
  logic       en_pin;
  logic [7:0] data_pins;
  logic [1:0] hold_ms;
  logic       last;

  modport source (output valid, rs_pin, en_pin, data_pins, hold_ms, last, input ready);
  modport sink (input valid, rs_pin, en_pin, data_pins, hold_ms, last, output ready);
endinterface

// ===== hw/rtl/clbs_cfg_if.sv =====
interface clbs_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/clbs_ctrl.sv =====
module clbs_ctrl
  import clbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_sts_t sts_i,
  output logic      req_ready_o,
  output ctrl_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic       init_q, init_d;
  logic [2:0] idx_q, idx_d;
  logic       nib_q, nib_d;
  logic [1:0] ph_q, ph_d;
  logic       word_final;

  // final word: last init command or the only/low part of a write
  assign word_final = (!init_q || idx_q == IDX_ENTRY) && (sts_i.wide_bus || nib_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.req_valid) state_d = ST_BUSY;
      end
      ST_BUSY: begin
        if (cmd_o.push && cmd_o.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o     = (state_q == ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && sts_i.req_valid;
    cmd_o.push      = (state_q == ST_BUSY) && sts_i.out_free;
    cmd_o.use_rom   = init_q;
    cmd_o.rom_idx   = idx_q;
    cmd_o.nib_lo    = nib_q;
    cmd_o.phase     = ph_q;
    cmd_o.last      = (ph_q == PH_EN_LO) && word_final;
  end

  always_comb begin
    init_d = init_q;
    idx_d  = idx_q;
    nib_d  = nib_q;
    ph_d   = ph_q;
    if (cmd_o.load) begin
      init_d = (sts_i.req_init == CMD_INIT);
      idx_d  = sts_i.wide_bus ? IDX_FUNC : IDX_PREFIX;
      nib_d  = 1'b0;
      ph_d   = PH_PLACE;
    end else if (cmd_o.push) begin
      if (ph_q != PH_EN_LO) begin
        ph_d = ph_q + 2'd1;
      end else begin
        ph_d = PH_PLACE;
        // the lone prefix nibble has no low half
        if (!sts_i.wide_bus && !nib_q && !(init_q && idx_q == IDX_PREFIX)) begin
          nib_d = 1'b1;
        end else begin
          nib_d = 1'b0;
          if (init_q && idx_q != IDX_ENTRY) idx_d = idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= 1'b0;
      idx_q   <= IDX_PREFIX;
      nib_q   <= 1'b0;
      ph_q    <= PH_PLACE;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      idx_q   <= idx_d;
      nib_q   <= nib_d;
      ph_q    <= ph_d;
    end
  end

endmodule

// ===== hw/rtl/clbs_dp.sv =====
module clbs_dp
  import clbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  logic       wide_bus_i,
  input  logic       reg_select_i,
  input  logic [7:0] byte_value_i,
  input  logic       out_ready_i,
  output logic       out_free_o,
  output logic       out_valid_o,
  output logic       rs_pin_o,
  output logic       en_pin_o,
  output logic [7:0] data_pins_o,
  output logic [1:0] hold_ms_o,
  output logic       last_o
);

  logic [7:0] byte_q;
  logic       rs_q;
  logic       valid_q;
  logic       rs_out_q, en_out_q, last_q;
  logic [7:0] data_q;
  logic [1:0] hold_q;
  logic [7:0] src;
  logic [7:0] word;

  assign src  = cmd_i.use_rom ? init_byte(cmd_i.rom_idx, wide_bus_i) : byte_q;
  assign word = wide_bus_i ? src
              : (cmd_i.nib_lo ? {src[3:0], 4'h0} : {src[7:4], 4'h0});

  assign out_free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= byte_value_i;
      rs_q   <= reg_select_i;
    end
    if (cmd_i.push) begin
      rs_out_q <= cmd_i.use_rom ? 1'b0 : rs_q;
      en_out_q <= (cmd_i.phase == PH_EN_HI);
      data_q   <= word;
      hold_q   <= cmd_i.phase;
      last_q   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign rs_pin_o    = rs_out_q;
  assign en_pin_o    = en_out_q;
  assign data_pins_o = data_q;
  assign hold_ms_o   = hold_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/char_lcd_bus_sequencer.sv =====
// Character LCD bus sequencer. Each request becomes a list of pin updates,
// one update leaving the output register per cycle while the sink is ready.
// Every bus word takes three updates: data placed with EN low (hold 0 ms),
// EN high (hold 1 ms), EN low (hold 2 ms). A byte write takes 3 updates on
// an 8-bit bus and 6 in 4-bit mode; init takes 12 (8-bit) or 27 (4-bit), RS
// low throughout. The updates are produced by the single word/strobe
// sequencer. The next request is taken once the final update is registered.
// The user must write bus width through the config channel only while idle;
// the block itself does not enforce it. Reset selects 4-bit mode.
module char_lcd_bus_sequencer
  import clbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  clbs_cfg_if.sink   cfg_i,
  clbs_req_if.sink   req_i,
  clbs_upd_if.source upd_o
);

  logic      wide_bus_q;
  ctrl_sts_t sts;
  ctrl_cmd_t cmd;
  logic      out_free;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_bus_q <= 1'b0;
    end else if (cfg_i.valid) begin
      wide_bus_q <= cfg_i.data;
    end
  end

  assign sts.req_valid = req_i.valid;
  assign sts.req_init  = req_i.cmd;
  assign sts.wide_bus  = wide_bus_q;
  assign sts.out_free  = out_free;

  clbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  clbs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .wide_bus_i   (wide_bus_q),
    .reg_select_i (req_i.reg_select),
    .byte_value_i (req_i.byte_value),
    .out_ready_i  (upd_o.ready),
    .out_free_o   (out_free),
    .out_valid_o  (upd_o.valid),
    .rs_pin_o     (upd_o.rs_pin),
    .en_pin_o     (upd_o.en_pin),
    .data_pins_o  (upd_o.data_pins),
    .hold_ms_o    (upd_o.hold_ms),
    .last_o       (upd_o.last)
  );

`ifndef SYNTHESIS
  // a request ends on the closing strobe edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_o.valid && upd_o.last |-> !upd_o.en_pin && upd_o.hold_ms == PH_EN_LO)
    else $error("final update is not the EN low step");

  // EN is only high on the 1 ms step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_o.valid && upd_o.en_pin |-> upd_o.hold_ms == PH_EN_HI)
    else $error("EN high with wrong hold time");

  // nibble mode never drives the low data lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_o.valid && !wide_bus_q |-> upd_o.data_pins[3:0] == 4'h0)
    else $error("low data lines driven in 4-bit mode");

  // an accepted request blocks the next one in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while busy");
`endif

endmodule
